@@ design/spa_pkg.sv @@
// shared types and constants for the softplus approximation pipeline
`default_nettype none

package spa_pkg;

  // field and register widths
  localparam int Y_W        = 23;
  localparam int A_W        = 23;
  localparam int R_W        = 32;
  localparam int MODE_W     = 2;
  localparam int REGION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // parameter defaults
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 24;

  // largest result
  localparam logic [Y_W-1:0] Y_MAX = '1;

  // register reset values
  localparam logic [A_W-1:0] HALF_WIDTH_RST = A_W'(65536);
  localparam logic [R_W-1:0] RECIP_RST      = R_W'(65536);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_IDX  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_IDX  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_IDX = CFG_IDX_W'(2);

  // function select
  typedef enum logic [MODE_W-1:0] {
    MODE_PARA_VAL  = 2'd0,
    MODE_PARA_DER  = 2'd1,
    MODE_QUART_VAL = 2'd2,
    MODE_CUBIC_DER = 2'd3
  } mode_t;

  // where the sample lies relative to the band
  typedef enum logic [REGION_W-1:0] {
    REG_BELOW = 2'd0,
    REG_BAND  = 2'd1,
    REG_ABOVE = 2'd2
  } region_t;

endpackage

`default_nettype wire

@@ design/softplus_polynomial_approx_core.sv @@
// softplus piecewise-polynomial approximation, eight-stage pipeline
// throughput: one item per cycle while out_stall is low; each stage holds its item
//   only while the next is full, so empty stages keep accepting while a finished
//   result waits at the output
// reset (synchronous, rst_n low): pipeline emptied, mode 0, half width and reciprocal 1.0
// widest step per stage: the 23 x 32 bit product of |x| and the reciprocal
`default_nettype none

module softplus_polynomial_approx_core #(
  parameter int FRAC_BITS  = spa_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = spa_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [spa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spa_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [DATA_WIDTH-1:0]      in_x_value,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spa_pkg::Y_W-1:0]           out_y_value,
  output logic [spa_pkg::REGION_W-1:0]      out_region
);

  import spa_pkg::*;

  // derived widths
  localparam int CMP_W = ((DATA_WIDTH > A_W) ? DATA_WIDTH : A_W) + 2;
  localparam int PR_W  = A_W + R_W;
  localparam int ZM_W  = PR_W - FRAC_BITS + 1;
  localparam int MZ_W  = FRAC_BITS + 1;
  localparam int W_W   = FRAC_BITS + 2;
  localparam int T_W   = FRAC_BITS + 3;
  localparam int PW    = FRAC_BITS + 7;
  localparam int PM_W  = FRAC_BITS + 5;
  localparam int YC_W  = (FRAC_BITS + 1 > Y_W + 1) ? FRAC_BITS + 1 : Y_W + 1;

  localparam logic [ZM_W-1:0]      Z_ONE   = ZM_W'(1) << FRAC_BITS;
  localparam logic [W_W-1:0]       W_ONE   = W_W'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] P_ONE   = PW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] P_ONE2  = P_ONE <<< 1;
  localparam logic signed [PW-1:0] P_ONE3  = P_ONE + (P_ONE <<< 1);
  localparam logic [Y_W-1:0]       ONE_SAT = (FRAC_BITS >= Y_W) ? Y_MAX
                                             : (Y_W'(1) << FRAC_BITS);

  // clip a candidate result to the output range
  function automatic logic [Y_W-1:0] sat_y(input logic [YC_W-1:0] v);
    logic [Y_W-1:0] r;
    if (v > YC_W'(Y_MAX)) begin
      r = Y_MAX;
    end else begin
      r = v[Y_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  mode_t          mode_r;
  logic [A_W-1:0] half_width_r;
  logic [R_W-1:0] recip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_PARA_VAL;
      half_width_r <= HALF_WIDTH_RST;
      recip_r      <= RECIP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE_IDX:  mode_r       <= mode_t'(cfg_wr_data[MODE_W-1:0]);
        CFG_HALF_IDX:  half_width_r <= cfg_wr_data[A_W-1:0];
        CFG_RECIP_IDX: recip_r      <= cfg_wr_data[R_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_valid_r;
  logic ce1, ce2, ce3, ce4, ce5, ce6, ce7, ce8;

  assign ce8 = !out_valid_r || !out_stall;
  assign ce7 = !v7_r || ce8;
  assign ce6 = !v6_r || ce7;
  assign ce5 = !v5_r || ce6;
  assign ce4 = !v4_r || ce5;
  assign ce3 = !v3_r || ce4;
  assign ce2 = !v2_r || ce3;
  assign ce1 = !v1_r || ce2;

  assign in_stall  = !ce1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ce1) v1_r <= in_valid;
      if (ce2) v2_r <= v1_r;
      if (ce3) v3_r <= v2_r;
      if (ce4) v4_r <= v3_r;
      if (ce5) v5_r <= v4_r;
      if (ce6) v6_r <= v5_r;
      if (ce7) v7_r <= v6_r;
      if (ce8) out_valid_r <= v7_r;
    end
  end

  // stage 1: sample capture
  logic signed [DATA_WIDTH-1:0] x1_r;

  always_ff @(posedge clk) begin
    if (ce1) x1_r <= in_x_value;
  end

  // stage 2: band compare, magnitude, result above the band
  logic signed [CMP_W-1:0] x2_s, a2_s, ax2;
  region_t                 region2_nxt, region2_r;
  logic [Y_W-1:0]          yhi2_nxt, yhi2_r;
  logic [A_W-1:0]          mx2_r;
  logic                    neg2_r;

  assign x2_s = CMP_W'(x1_r);
  assign a2_s = $signed(CMP_W'(half_width_r));
  assign ax2  = x2_s[CMP_W-1] ? -x2_s : x2_s;

  always_comb begin
    if (x2_s <= -a2_s) begin
      region2_nxt = REG_BELOW;
    end else if (x2_s >= a2_s) begin
      region2_nxt = REG_ABOVE;
    end else begin
      region2_nxt = REG_BAND;
    end
    // derivative modes give 1.0 above the band, value modes pass x
    if (mode_r == MODE_PARA_DER || mode_r == MODE_CUBIC_DER) begin
      yhi2_nxt = ONE_SAT;
    end else if (ax2 > CMP_W'(Y_MAX)) begin
      yhi2_nxt = Y_MAX;
    end else begin
      yhi2_nxt = ax2[Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce2) begin
      region2_r <= region2_nxt;
      yhi2_r    <= yhi2_nxt;
      mx2_r     <= ax2[A_W-1:0];
      neg2_r    <= x2_s[CMP_W-1];
    end
  end

  // stage 3: |x| times the reciprocal
  logic [PR_W-1:0] prod3_nxt, prod3_r;
  region_t         region3_r;
  logic [Y_W-1:0]  yhi3_r;
  logic            neg3_r;

  assign prod3_nxt = PR_W'(mx2_r) * PR_W'(recip_r);

  always_ff @(posedge clk) begin
    if (ce3) begin
      prod3_r   <= prod3_nxt;
      region3_r <= region2_r;
      yhi3_r    <= yhi2_r;
      neg3_r    <= neg2_r;
    end
  end

  // stage 4: z rounded toward minus infinity and held to [-1, 1], w = z + 1
  logic [ZM_W-1:0] mfl4, mce4, msel4;
  logic [MZ_W-1:0] mz4_nxt, mz4_r;
  logic [W_W-1:0]  w4_nxt, w4_r;
  region_t         region4_r;
  logic [Y_W-1:0]  yhi4_r;
  logic            zneg4_r;

  assign mfl4    = ZM_W'(prod3_r[PR_W-1:FRAC_BITS]);
  assign mce4    = mfl4 + ZM_W'(|prod3_r[FRAC_BITS-1:0]);
  assign msel4   = neg3_r ? mce4 : mfl4;
  assign mz4_nxt = (msel4 > Z_ONE) ? MZ_W'(Z_ONE) : msel4[MZ_W-1:0];
  assign w4_nxt  = neg3_r ? (W_ONE - W_W'(mz4_nxt)) : (W_ONE + W_W'(mz4_nxt));

  always_ff @(posedge clk) begin
    if (ce4) begin
      mz4_r     <= mz4_nxt;
      w4_r      <= w4_nxt;
      zneg4_r   <= neg3_r;
      region4_r <= region3_r;
      yhi4_r    <= yhi3_r;
    end
  end

  // stage 5: z squared and w squared
  logic [2*MZ_W-1:0] zz5;
  logic [2*W_W-1:0]  ww5;
  logic [MZ_W-1:0]   z2_5_r, mz5_r;
  logic [T_W-1:0]    t5_r;
  logic [W_W-1:0]    w5_r;
  region_t           region5_r;
  logic [Y_W-1:0]    yhi5_r;
  logic              zneg5_r;

  assign zz5 = (2*MZ_W)'(mz4_r) * (2*MZ_W)'(mz4_r);
  assign ww5 = (2*W_W)'(w4_r) * (2*W_W)'(w4_r);

  always_ff @(posedge clk) begin
    if (ce5) begin
      z2_5_r    <= zz5[2*FRAC_BITS:FRAC_BITS];
      t5_r      <= ww5[2*FRAC_BITS+2:FRAC_BITS];
      mz5_r     <= mz4_r;
      w5_r      <= w4_r;
      zneg5_r   <= zneg4_r;
      region5_r <= region4_r;
      yhi5_r    <= yhi4_r;
    end
  end

  // stage 6: z^4, |z|^3 and the parabolic value product
  logic [2*MZ_W-1:0]     z4p6, z3p6;
  logic [T_W+A_W-1:0]    y0p6;
  logic [MZ_W-1:0]       z4_6_r, z3_6_r, z2_6_r, mz6_r;
  logic [Y_W:0]          y0_6_r;
  logic [W_W-1:0]        w6_r;
  region_t               region6_r;
  logic [Y_W-1:0]        yhi6_r;
  logic                  zneg6_r;

  assign z4p6 = (2*MZ_W)'(z2_5_r) * (2*MZ_W)'(z2_5_r);
  assign z3p6 = (2*MZ_W)'(mz5_r) * (2*MZ_W)'(z2_5_r);
  assign y0p6 = (T_W+A_W)'(t5_r) * (T_W+A_W)'(half_width_r);

  always_ff @(posedge clk) begin
    if (ce6) begin
      z4_6_r    <= z4p6[2*FRAC_BITS:FRAC_BITS];
      z3_6_r    <= z3p6[2*FRAC_BITS:FRAC_BITS];
      y0_6_r    <= y0p6[T_W+A_W-1:FRAC_BITS+2];
      z2_6_r    <= z2_5_r;
      mz6_r     <= mz5_r;
      w6_r      <= w5_r;
      zneg6_r   <= zneg5_r;
      region6_r <= region5_r;
      yhi6_r    <= yhi5_r;
    end
  end

  // stage 7: polynomial sums, results for all modes but the quartic value
  logic signed [PW-1:0] z_s, z2_s, z4_s, z3_s, p2_7, p3_7, p3q_7;
  logic [PM_W-1:0]      pm7_nxt, pm7_r;
  logic [MZ_W-1:0]      y3_7;
  logic [Y_W-1:0]       ysel7_nxt, ysel7_r;
  region_t              region7_r;
  logic [Y_W-1:0]       yhi7_r;

  assign z_s   = zneg6_r ? -$signed(PW'(mz6_r)) : $signed(PW'(mz6_r));
  assign z2_s  = $signed(PW'(z2_6_r));
  assign z4_s  = $signed(PW'(z4_6_r));
  assign z3_s  = zneg6_r ? -$signed(PW'(z3_6_r)) : $signed(PW'(z3_6_r));

  // -z^4 + 6 z^2 + 8 z + 3 and -z^3 + 3 z + 2
  assign p2_7  = (z2_s <<< 2) + (z2_s <<< 1) + (z_s <<< 3) + P_ONE3 - z4_s;
  assign p3_7  = P_ONE2 + (z_s <<< 1) + z_s - z3_s;
  assign p3q_7 = p3_7 >>> 2;

  // a polynomial that truncation pushed to zero or below gives zero
  assign pm7_nxt = (!p2_7[PW-1] && (p2_7 != '0)) ? p2_7[PM_W-1:0] : '0;
  assign y3_7    = (!p3_7[PW-1] && (p3_7 != '0)) ? p3q_7[MZ_W-1:0] : '0;

  always_comb begin
    case (mode_r)
      MODE_PARA_VAL:  ysel7_nxt = sat_y(YC_W'(y0_6_r));
      MODE_PARA_DER:  ysel7_nxt = sat_y(YC_W'(w6_r[W_W-1:1]));
      MODE_QUART_VAL: ysel7_nxt = '0;
      MODE_CUBIC_DER: ysel7_nxt = sat_y(YC_W'(y3_7));
      default:        ysel7_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce7) begin
      pm7_r     <= pm7_nxt;
      ysel7_r   <= ysel7_nxt;
      region7_r <= region6_r;
      yhi7_r    <= yhi6_r;
    end
  end

  // stage 8: quartic value scaling by a, region select, output register
  logic [PM_W+A_W-1:0] pa8;
  logic [Y_W-1:0]      yband8, out_y_nxt, out_y_r;
  region_t             out_region_r;

  assign pa8    = (PM_W+A_W)'(pm7_r) * (PM_W+A_W)'(half_width_r);
  assign yband8 = (mode_r == MODE_QUART_VAL)
                  ? sat_y(YC_W'(pa8[PM_W+A_W-1:FRAC_BITS+4])) : ysel7_r;

  always_comb begin
    case (region7_r)
      REG_BELOW: out_y_nxt = '0;
      REG_BAND:  out_y_nxt = yband8;
      REG_ABOVE: out_y_nxt = yhi7_r;
      default:   out_y_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce8) begin
      out_y_r      <= out_y_nxt;
      out_region_r <= region7_r;
    end
  end

  assign out_y_value = out_y_r;
  assign out_region  = out_region_r;

  // checks
  a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_region_r == REG_BELOW) |-> (out_y_r == '0))
    else $error("result below the band is not zero");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && v5_r && v6_r && v7_r
                  && out_valid_r && out_stall))
    else $error("input stalled with an empty stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted item missing from first stage");

  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v7_r && ce8) |=> out_valid_r)
    else $error("item lost between last stage and output");

endmodule

`default_nettype wire
